// ===== hdl/bipf_pkg.sv =====
// Shared constants, types and status codes for the BST insertion parent finder.
package bipf_pkg;

   localparam int IO_KEY_BITS      = 32;
   localparam int DEFAULT_CAPACITY = 1024;
   localparam int DEFAULT_KEY_BITS = 32;
   localparam int FLAG_BITS        = 2;
   localparam int FLAG_LEFT_BIT    = 0;
   localparam int FLAG_RIGHT_BIT   = 1;

   typedef enum logic [1:0] {
      STATUS_PARENT    = 2'd0,
      STATUS_ROOT      = 2'd1,
      STATUS_DUPLICATE = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SRCH  = 8'b0000_0010,
      ST_SCMP  = 8'b0000_0100,
      ST_SUCC  = 8'b0000_1000,
      ST_PRED  = 8'b0001_0000,
      ST_SHIFT = 8'b0010_0000,
      ST_DRAIN = 8'b0100_0000,
      ST_INS   = 8'b1000_0000
   } state_type;

endpackage

// ===== hdl/bst_insert_parent_finder.sv =====
// Steps: binary search over the stored keys, neighbor lookup, then a shift of the keys
//   above the insert point up one slot and the insert of the new key.
// Duplicate and full cases finish after the search, at the latest in the successor check.
// Throughput: one key at a time; busy stays high until the result strobe, never stalled.
// The table RAM (one read, one write per cycle) sets the shift time.
// Reset: synchronous, clears the key count and control; RAM contents are left as is.
module bst_insert_parent_finder
   import bipf_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int KEY_BITS = DEFAULT_KEY_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [IO_KEY_BITS-1:0] req_key,
   output logic                   rsp_valid,
   output logic [IO_KEY_BITS-1:0] rsp_parent_key,
   output logic [1:0]             rsp_status
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int ENT_W  = KEY_BITS + FLAG_BITS;

   logic [KEY_BITS+IO_KEY_BITS-1:0] key_wide;
   logic [KEY_BITS+IO_KEY_BITS-1:0] parent_wide;
   logic [KEY_BITS-1:0]             parent;
   status_type                      status;
   logic                            wr_en, rd_en;
   logic [ADDR_W-1:0]               wr_addr, rd_addr;
   logic [ENT_W-1:0]                wr_data, rd_data;

   assign key_wide       = {{KEY_BITS{1'b0}}, req_key};
   assign parent_wide    = {{IO_KEY_BITS{1'b0}}, parent};
   assign rsp_parent_key = parent_wide[IO_KEY_BITS-1:0];
   assign rsp_status     = status;

   bipf_ctrl #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .key         (key_wide[KEY_BITS-1:0]),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_parent  (parent),
      .rsp_status  (status),
      .mem_wr_en   (wr_en),
      .mem_wr_addr (wr_addr),
      .mem_wr_data (wr_data),
      .mem_rd_en   (rd_en),
      .mem_rd_addr (rd_addr),
      .mem_rd_data (rd_data)
   );

   bipf_ram #(
      .WIDTH (ENT_W),
      .DEPTH (CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== hdl/bipf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bipf_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bipf_ctrl.sv =====
// Sequencer: binary search, neighbor lookup, flag update, table shift and insert.
module bipf_ctrl
   import bipf_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int KEY_BITS = DEFAULT_KEY_BITS,
   localparam int ADDR_W  = $clog2(CAPACITY),
   localparam int CNT_W   = $clog2(CAPACITY + 1),
   localparam int ENT_W   = KEY_BITS + FLAG_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [KEY_BITS-1:0] key,
   output logic              busy,
   output logic              rsp_valid,
   output logic [KEY_BITS-1:0] rsp_parent,
   output status_type        rsp_status,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output logic [ENT_W-1:0]  mem_wr_data,
   output logic              mem_rd_en,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  logic [ENT_W-1:0]  mem_rd_data
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [CNT_W-1:0]    mid;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] succ_ff, succ_in;
   logic [KEY_BITS-1:0] parent_ff, parent_in;
   status_type          status_ff, status_in;
   logic                mark_ff, mark_in;
   logic [ADDR_W-1:0]   rd_idx_ff, rd_idx_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [KEY_BITS-1:0]  rd_key;
   logic [FLAG_BITS-1:0] rd_flags;
   logic [ADDR_W-1:0]    pos_a;
   logic [ADDR_W-1:0]    pos_plus1;
   logic [FLAG_BITS-1:0] shift_flags;

   assign rd_key    = mem_rd_data[ENT_W-1:FLAG_BITS];
   assign rd_flags  = mem_rd_data[FLAG_BITS-1:0];
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign pos_a     = lo_ff[ADDR_W-1:0];
   assign pos_plus1 = pos_a + ADDR_W'(1);

   // Carry the successor's left-child mark along as it moves up one slot.
   always_comb begin
      shift_flags = rd_flags;
      if (mark_ff && pend_addr_ff == pos_plus1) begin
         shift_flags[FLAG_LEFT_BIT] = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      key_in       = key_ff;
      succ_in      = succ_ff;
      parent_in    = parent_ff;
      status_in    = status_ff;
      mark_in      = mark_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      rsp_valid_in = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = pos_a;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = pend_addr_ff;
      mem_wr_data  = {rd_key, shift_flags};

      if (pend_ff) begin
         mem_wr_en = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in    = key;
               lo_in     = '0;
               hi_in     = count_ff;
               mark_in   = 1'b0;
               parent_in = '0;
               status_in = STATUS_PARENT;
               state_in  = ST_SRCH;
            end
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mid[ADDR_W-1:0];
               state_in    = ST_SCMP;
            end else if (lo_ff < count_ff) begin
               mem_rd_en = 1'b1;
               state_in  = ST_SUCC;
            end else if (count_ff == CAP_CNT) begin
               status_in    = STATUS_FULL;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (count_ff == '0) begin
               status_in = STATUS_ROOT;
               state_in  = ST_INS;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = pos_a - ADDR_W'(1);
               state_in    = ST_PRED;
            end
         end
         ST_SCMP: begin
            if (rd_key < key_ff) begin
               lo_in = mid + CNT_W'(1);
            end else begin
               hi_in = mid;
            end
            state_in = ST_SRCH;
         end
         ST_SUCC: begin
            succ_in = rd_key;
            if (rd_key == key_ff) begin
               status_in    = STATUS_DUPLICATE;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (count_ff == CAP_CNT) begin
               status_in    = STATUS_FULL;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (lo_ff == '0) begin
               parent_in = rd_key;
               mark_in   = 1'b1;
               rd_idx_in = count_ff[ADDR_W-1:0] - ADDR_W'(1);
               state_in  = ST_SHIFT;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = pos_a - ADDR_W'(1);
               state_in    = ST_PRED;
            end
         end
         ST_PRED: begin
            if (!rd_flags[FLAG_RIGHT_BIT]) begin
               parent_in   = rd_key;
               mem_wr_en   = 1'b1;
               mem_wr_addr = pos_a - ADDR_W'(1);
               mem_wr_data = {rd_key, rd_flags | FLAG_BITS'(1 << FLAG_RIGHT_BIT)};
            end else if (lo_ff < count_ff) begin
               parent_in = succ_ff;
               mark_in   = 1'b1;
            end else begin
               parent_in = rd_key;
            end
            rd_idx_in = count_ff[ADDR_W-1:0] - ADDR_W'(1);
            state_in  = (lo_ff < count_ff) ? ST_SHIFT : ST_INS;
         end
         ST_SHIFT: begin
            // Read slot i while the entry from slot i+1 is written to i+2.
            mem_rd_en    = 1'b1;
            mem_rd_addr  = rd_idx_ff;
            pend_in      = 1'b1;
            pend_addr_in = rd_idx_ff + ADDR_W'(1);
            rd_idx_in    = rd_idx_ff - ADDR_W'(1);
            if (rd_idx_ff == pos_a) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_INS;
         end
         ST_INS: begin
            mem_wr_en    = 1'b1;
            mem_wr_addr  = pos_a;
            mem_wr_data  = {key_ff, FLAG_BITS'(0)};
            count_in     = count_ff + CNT_W'(1);
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      key_ff       <= key_in;
      succ_ff      <= succ_in;
      parent_ff    <= parent_in;
      status_ff    <= status_in;
      mark_ff      <= mark_in;
      rd_idx_ff    <= rd_idx_in;
      pend_addr_ff <= pend_addr_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_parent = (status_ff == STATUS_PARENT) ? parent_ff : '0;

endmodule

// ===== hdl/bipf_check.sv =====
// Port-level checker for the BST insertion parent finder, bound to the top level.
module bipf_check
   import bipf_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input logic [IO_KEY_BITS-1:0] rsp_parent_key,
   input logic [1:0]             rsp_status
);

   // A result beat only ends a busy period.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
      else $error("result beat without a busy period");

   // An accepted key keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted key did not raise busy");

   // Every busy period ends with exactly one result beat.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // Parent key reads zero unless a parent was found.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_PARENT |-> rsp_parent_key == '0)
      else $error("nonzero parent key with non-parent status");

   // Reset leaves the block idle with no result.
   assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind bst_insert_parent_finder bipf_check u_bipf_check (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_parent_key (rsp_parent_key),
   .rsp_status     (rsp_status)
);
